### hdl/pdfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PD controller with filtered derivative.
// Used by the register file, divider, datapath, controller and top level.
package pdfd_pkg;

    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 26;
    localparam int unsigned DIVIDEND_W   = 30;
    localparam int unsigned DIVISOR_W    = 16;
    localparam int unsigned DIV_CNT_W    = $clog2(DIVIDEND_W);
    localparam int unsigned NORM_ONE     = 16384;
    localparam int unsigned NORM_SHIFT   = 14;
    localparam int unsigned ALPHA_SHIFT  = 16;
    localparam int unsigned MS_PER_S     = 1000;

    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_MAX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MAX = 3'd5;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_DIV_E  = 4'd2;
    localparam logic [3:0] OP_CAP_E  = 4'd3;
    localparam logic [3:0] OP_MUL_P  = 4'd4;
    localparam logic [3:0] OP_CAP_P  = 4'd5;
    localparam logic [3:0] OP_DIV_S  = 4'd6;
    localparam logic [3:0] OP_CAP_S  = 4'd7;
    localparam logic [3:0] OP_MUL_A  = 4'd8;
    localparam logic [3:0] OP_MUL_B  = 4'd9;
    localparam logic [3:0] OP_CAP_F  = 4'd10;
    localparam logic [3:0] OP_MUL_KD = 4'd11;
    localparam logic [3:0] OP_CAP_D  = 4'd12;
    localparam logic [3:0] OP_OUT    = 4'd13;

    typedef struct packed {
        logic signed [15:0] kp_gain;
        logic signed [15:0] kd_gain;
        logic [14:0]        error_max;
        logic [25:0]        derivative_max;
        logic [15:0]        filter_alpha;
        logic [14:0]        output_max;
    } t_cfg;

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_status;

endpackage

### hdl/pdfd_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file for the PD controller.
// Depends on pdfd_pkg for the register indexes and the t_cfg type.
module pdfd_cfg_regs
    import pdfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain        <= 16'sd256;
            r_cfg.kd_gain        <= 16'sd0;
            r_cfg.error_max      <= 15'd3500;
            r_cfg.derivative_max <= 26'd163840;
            r_cfg.filter_alpha   <= 16'd52429;
            r_cfg.output_max     <= 15'd256;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_KP_GAIN:    r_cfg.kp_gain        <= $signed(i_cfg_data[15:0]);
                CFG_KD_GAIN:    r_cfg.kd_gain        <= $signed(i_cfg_data[15:0]);
                CFG_ERROR_MAX:  r_cfg.error_max      <= i_cfg_data[14:0];
                CFG_DERIV_MAX:  r_cfg.derivative_max <= i_cfg_data[25:0];
                CFG_ALPHA:      r_cfg.filter_alpha   <= i_cfg_data[15:0];
                CFG_OUTPUT_MAX: r_cfg.output_max     <= i_cfg_data[14:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/pdfd_div.sv
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on pdfd_pkg for the operand widths.
module pdfd_div
    import pdfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    trial;

    assign shifted = {r_rem, r_quo[DIVIDEND_W-1]};
    assign trial   = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            if (!trial[DIVISOR_W]) begin
                r_rem <= trial[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[DIVISOR_W-1:0];
                r_quo <= {r_quo[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

### hdl/pdfd_datapath.sv
`timescale 1ns / 1ps
// Datapath of the PD controller: shared multiplier, divider, state and result registers.
// Depends on pdfd_pkg and instantiates pdfd_div.
module pdfd_datapath
    import pdfd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic signed [15:0] i_error_sample,
    input  logic [15:0]        i_elapsed_ms,
    input  logic               i_restart,
    output logic signed [15:0] o_correction,
    output logic signed [15:0] o_p_term,
    output logic signed [23:0] o_d_term
);

    function automatic logic signed [47:0] f_trunc_shr(input logic signed [47:0] x,
                                                      input logic [4:0] sh);
        logic signed [47:0] bias;
        bias = x[47] ? ((48'sd1 <<< sh) - 48'sd1) : 48'sd0;
        return (x + bias) >>> sh;
    endfunction

    logic signed [15:0] r_err;
    logic [15:0]        r_ms;
    logic               r_neg;
    logic signed [15:0] r_e;
    logic signed [15:0] r_last;
    logic               r_first;
    logic signed [26:0] r_slope;
    logic signed [27:0] r_filt;
    logic signed [45:0] r_prod;
    logic signed [45:0] r_acc;
    logic signed [15:0] r_p;
    logic signed [31:0] r_d;
    logic signed [15:0] r_out_corr;
    logic signed [15:0] r_out_p;
    logic signed [23:0] r_out_d;

    logic                  div_start;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DIVIDEND_W-1:0] div_q;

    logic signed [16:0] err_ext;
    logic signed [16:0] err_abs;
    logic signed [45:0] prod_abs;
    logic [14:0]        emax_eff;
    logic signed [47:0] prod_x;
    logic signed [47:0] p48;
    logic signed [47:0] d48;
    logic signed [47:0] f48;
    logic signed [47:0] sum48;
    logic [14:0]        e_mag;
    logic signed [15:0] e_mag_s;
    logic [25:0]        s_mag;
    logic signed [26:0] s_mag_s;
    logic signed [16:0] diff;
    logic [16:0]        alpha_c;
    logic               mul_en;
    logic signed [17:0] mul_a;
    logic signed [27:0] mul_b;
    logic signed [45:0] mul_p;
    logic signed [32:0] sum33;
    logic signed [32:0] omax_pos;
    logic signed [32:0] omax_neg;
    logic signed [15:0] corr_v;
    logic signed [23:0] dsat_v;

    assign err_ext  = {r_err[15], r_err};
    assign err_abs  = err_ext[16] ? -err_ext : err_ext;
    assign prod_abs = r_prod[45] ? -r_prod : r_prod;
    assign emax_eff = (i_cfg.error_max == '0) ? 15'd1 : i_cfg.error_max;
    assign prod_x   = {{2{r_prod[45]}}, r_prod};
    assign p48      = f_trunc_shr(prod_x, 5'(NORM_SHIFT));
    assign d48      = f_trunc_shr(prod_x, 5'(NORM_SHIFT));
    assign sum48    = {{2{r_acc[45]}}, r_acc} + prod_x;
    assign f48      = f_trunc_shr(sum48, 5'(ALPHA_SHIFT));
    assign diff     = {r_e[15], r_e} - {r_last[15], r_last};
    assign alpha_c  = 17'h10000 - {1'b0, i_cfg.filter_alpha};

    assign e_mag   = (div_q > DIVIDEND_W'(NORM_ONE)) ? 15'(NORM_ONE) : div_q[14:0];
    assign e_mag_s = {1'b0, e_mag};
    assign s_mag   = (div_q > {4'b0, i_cfg.derivative_max}) ? i_cfg.derivative_max
                                                            : div_q[25:0];
    assign s_mag_s = {1'b0, s_mag};

    assign div_start = (i_cmd.op == OP_DIV_E) || (i_cmd.op == OP_DIV_S);

    always_comb begin
        div_dividend = prod_abs[DIVIDEND_W-1:0];
        div_divisor  = r_ms;
        if (i_cmd.op == OP_DIV_E) begin
            div_dividend = {err_abs[15:0], 14'b0};
            div_divisor  = {1'b0, emax_eff};
        end
    end

    pdfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (i_cmd.op)
            OP_MUL_P: begin
                mul_a = {{2{i_cfg.kp_gain[15]}}, i_cfg.kp_gain};
                mul_b = {{12{r_e[15]}}, r_e};
            end
            OP_CAP_P: begin
                mul_a = 18'(MS_PER_S);
                mul_b = {{11{diff[16]}}, diff};
            end
            OP_MUL_A: begin
                mul_a = {2'b00, i_cfg.filter_alpha};
                mul_b = r_filt;
            end
            OP_MUL_B: begin
                mul_a = {1'b0, alpha_c};
                mul_b = {r_slope[26], r_slope};
            end
            OP_MUL_KD: begin
                mul_a = {{2{i_cfg.kd_gain[15]}}, i_cfg.kd_gain};
                mul_b = r_filt;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign sum33    = {{17{r_p[15]}}, r_p} + {r_d[31], r_d};
    assign omax_pos = {18'b0, i_cfg.output_max};
    assign omax_neg = -omax_pos;

    always_comb begin
        if (sum33 > omax_pos) begin
            corr_v = omax_pos[15:0];
        end else if (sum33 < omax_neg) begin
            corr_v = omax_neg[15:0];
        end else begin
            corr_v = sum33[15:0];
        end
        if (r_d > 32'sd8388607) begin
            dsat_v = 24'sh7FFFFF;
        end else if (r_d < -32'sd8388608) begin
            dsat_v = 24'sh800000;
        end else begin
            dsat_v = r_d[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_filt  <= '0;
            r_first <= 1'b1;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    if (i_restart) begin
                        r_last  <= '0;
                        r_filt  <= '0;
                        r_first <= 1'b1;
                    end
                end
                OP_CAP_S: begin
                    r_last  <= r_e;
                    r_first <= 1'b0;
                end
                OP_CAP_F: begin
                    r_filt <= f48[27:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
        case (i_cmd.op)
            OP_LOAD: begin
                r_err <= i_error_sample;
                r_ms  <= (i_elapsed_ms == '0) ? 16'd1 : i_elapsed_ms;
            end
            OP_DIV_E: begin
                r_neg <= err_ext[16];
            end
            OP_CAP_E: begin
                r_e <= r_neg ? -e_mag_s : e_mag_s;
            end
            OP_CAP_P: begin
                if (p48 > 48'sd32767) begin
                    r_p <= 16'sh7FFF;
                end else if (p48 < -48'sd32768) begin
                    r_p <= 16'sh8000;
                end else begin
                    r_p <= p48[15:0];
                end
            end
            OP_DIV_S: begin
                r_neg <= r_prod[45];
            end
            OP_CAP_S: begin
                if (r_first) begin
                    r_slope <= '0;
                end else begin
                    r_slope <= r_neg ? -s_mag_s : s_mag_s;
                end
            end
            OP_MUL_B: begin
                r_acc <= r_prod;
            end
            OP_CAP_D: begin
                r_d <= d48[31:0];
            end
            OP_OUT: begin
                r_out_corr <= corr_v;
                r_out_p    <= r_p;
                r_out_d    <= dsat_v;
            end
            default: begin
            end
        endcase
    end

    assign o_status.div_done = div_done;
    assign o_correction      = r_out_corr;
    assign o_p_term          = r_out_p;
    assign o_d_term          = r_out_d;

endmodule

### hdl/pdfd_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine that sequences one transaction through the datapath.
// Depends on pdfd_pkg for the command and status types and operation codes.
module pdfd_ctrl
    import pdfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DIV_E  = 4'd1;
    localparam logic [3:0] ST_WAIT_E = 4'd2;
    localparam logic [3:0] ST_CAP_E  = 4'd3;
    localparam logic [3:0] ST_MUL_P  = 4'd4;
    localparam logic [3:0] ST_CAP_P  = 4'd5;
    localparam logic [3:0] ST_DIV_S  = 4'd6;
    localparam logic [3:0] ST_WAIT_S = 4'd7;
    localparam logic [3:0] ST_CAP_S  = 4'd8;
    localparam logic [3:0] ST_MUL_A  = 4'd9;
    localparam logic [3:0] ST_MUL_B  = 4'd10;
    localparam logic [3:0] ST_CAP_F  = 4'd11;
    localparam logic [3:0] ST_MUL_KD = 4'd12;
    localparam logic [3:0] ST_CAP_D  = 4'd13;
    localparam logic [3:0] ST_OUT    = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = OP_NONE;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_DIV_E;
                end
            end
            ST_DIV_E: begin
                o_cmd.op = OP_DIV_E;
                n_state  = ST_WAIT_E;
            end
            ST_WAIT_E: begin
                if (i_status.div_done) begin
                    n_state = ST_CAP_E;
                end
            end
            ST_CAP_E: begin
                o_cmd.op = OP_CAP_E;
                n_state  = ST_MUL_P;
            end
            ST_MUL_P: begin
                o_cmd.op = OP_MUL_P;
                n_state  = ST_CAP_P;
            end
            ST_CAP_P: begin
                o_cmd.op = OP_CAP_P;
                n_state  = ST_DIV_S;
            end
            ST_DIV_S: begin
                o_cmd.op = OP_DIV_S;
                n_state  = ST_WAIT_S;
            end
            ST_WAIT_S: begin
                if (i_status.div_done) begin
                    n_state = ST_CAP_S;
                end
            end
            ST_CAP_S: begin
                o_cmd.op = OP_CAP_S;
                n_state  = ST_MUL_A;
            end
            ST_MUL_A: begin
                o_cmd.op = OP_MUL_A;
                n_state  = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd.op = OP_MUL_B;
                n_state  = ST_CAP_F;
            end
            ST_CAP_F: begin
                o_cmd.op = OP_CAP_F;
                n_state  = ST_MUL_KD;
            end
            ST_MUL_KD: begin
                o_cmd.op = OP_MUL_KD;
                n_state  = ST_CAP_D;
            end
            ST_CAP_D: begin
                o_cmd.op = OP_CAP_D;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.op == OP_OUT) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("controller accepted a transaction but stayed idle");

    a_done_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == ST_WAIT_E || r_state == ST_WAIT_S))
        else $error("divider finished while controller was not waiting");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_cmd.op == OP_OUT))
        else $error("output valid rose without a result load");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |-> out_free)
        else $error("result loaded over a stalled transaction");

endmodule

### hdl/pd_controller_filtered_derivative.sv
`timescale 1ns / 1ps
// PD controller with a low-pass filtered derivative term, fixed point.
// Instantiates pdfd_cfg_regs, pdfd_datapath and pdfd_ctrl; uses pdfd_pkg.
//
// Input channel: i_in_valid with o_in_stall carries error_sample, elapsed_ms
// and restart. A transaction is taken at a clock edge with valid high and
// stall low. Output channel: o_out_valid with i_out_stall carries correction,
// p_term and d_term, one result per input transaction.
// Configuration: i_cfg_valid/o_cfg_ready with a register index and data;
// ready is always high and writes are expected only while the block is idle.
// A new input is taken only after the controller has loaded the previous result
// and returned to idle. Most of the work is two 30-step passes through the
// single shared restoring divider (error normalization and slope); the single
// shared multiplier accounts for five more steps.
// Synchronous reset restores the register defaults, clears the stored error
// and filter state and marks the next sample as the first. A stalled result
// holds in the output register while the next input is processed; the block
// waits only when a new result is ready and the previous one is still held.
module pd_controller_filtered_derivative
    import pdfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [15:0]    i_error_sample,
    input  logic [15:0]           i_elapsed_ms,
    input  logic                  i_restart,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [15:0]    o_correction,
    output logic signed [15:0]    o_p_term,
    output logic signed [23:0]    o_d_term,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    pdfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pdfd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_error_sample (i_error_sample),
        .i_elapsed_ms   (i_elapsed_ms),
        .i_restart      (i_restart),
        .o_correction   (o_correction),
        .o_p_term       (o_p_term),
        .o_d_term       (o_d_term)
    );

    pdfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

endmodule
